FILE: rtl/particle_cell_list_binner_unit_macros.svh
// Assertion macros shared by the cell list binner RTL.
`ifndef PARTICLE_CELL_LIST_BINNER_UNIT_MACROS_SVH
`define PARTICLE_CELL_LIST_BINNER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define PCLB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pclb assertion failed");

// Next-cycle implication, sampled on clk, off during rst.
`define PCLB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pclb assertion failed");

`endif

FILE: rtl/pclb_pkg.sv
// Shared types and constants of the cell list binner.
`default_nettype none
package pclb_pkg;

  localparam int unsigned POS_W       = 24;
  localparam int unsigned CELL_SIZE_W = 23;
  localparam int unsigned DIM_REG_W   = 7;
  localparam int unsigned PID_W       = 12;
  localparam int unsigned LINK_W      = 13;
  localparam int unsigned CFG_IDX_W   = 2;

  localparam logic [LINK_W-1:0] LINK_NONE = 13'd4096;

  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS = 2'd2;

  localparam logic [CELL_SIZE_W-1:0] CELL_SIZE_RST = 23'd4096;
  localparam logic [DIM_REG_W-1:0]   GRID_DIM_RST  = 7'd64;

  typedef struct packed {
    logic                    first_of_frame;
    logic [PID_W-1:0]        particle_id;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
  } req_t;

  typedef struct packed {
    logic [5:0]        cell_col;
    logic [5:0]        cell_row;
    logic [11:0]       cell_slot;
    logic [LINK_W-1:0] link_to;
  } rsp_t;

  typedef struct packed {
    logic busy;
    logic neg;
    logic ovf;
  } div_stat_t;

endpackage
`default_nettype wire

FILE: rtl/pclb_coord_div.sv
// Bit-serial restoring divider that bins one coordinate and clamps it.
`default_nettype none
module pclb_coord_div #(
  parameter int unsigned QUOT_W = 6
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [pclb_pkg::POS_W-1:0]           raw,
  input  logic [pclb_pkg::CELL_SIZE_W-1:0]     divisor,
  input  logic [QUOT_W-1:0]                    hi,
  output pclb_pkg::div_stat_t                  stat,
  output logic [QUOT_W-1:0]                    q
);

  localparam int unsigned MAG_W = pclb_pkg::CELL_SIZE_W;
  localparam int unsigned RW    = MAG_W + QUOT_W;
  localparam int unsigned SW    = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

  logic              run;
  logic              neg;
  logic              ovf;
  logic [MAG_W-1:0]  rem;
  logic [MAG_W-1:0]  dvs;
  logic [QUOT_W-1:0] q_acc;
  logic [SW-1:0]     step;
  logic [RW-1:0]     trial;
  logic [RW-1:0]     over_lim;
  logic              take;

  assign over_lim = RW'(divisor) << QUOT_W;
  assign trial    = RW'(dvs) << step;
  assign take     = RW'(rem) >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
    end else if (start) begin
      run <= 1'b1;
    end else if (run && step == '0) begin
      run <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step  <= SW'(QUOT_W - 1);
      rem   <= raw[MAG_W-1:0];
      neg   <= raw[pclb_pkg::POS_W-1];
      dvs   <= divisor;
      ovf   <= RW'(raw[MAG_W-1:0]) >= over_lim;
      q_acc <= '0;
    end else if (run) begin
      if (take) begin
        rem <= rem - trial[MAG_W-1:0];
      end
      q_acc <= {q_acc[QUOT_W-2:0], take};
      step  <= step - 1'b1;
    end
  end

  // Clamp: negative or zero quotient goes to 1, anything past hi goes to hi.
  always_comb begin
    if (neg || q_acc == '0) begin
      q = QUOT_W'(1);
    end else if (ovf || q_acc > hi) begin
      q = hi;
    end else begin
      q = q_acc;
    end
  end

  assign stat.busy = run;
  assign stat.neg  = neg;
  assign stat.ovf  = ovf;

endmodule
`default_nettype wire

FILE: rtl/pclb_head_ram.sv
// Single-port-write, registered-read memory holding the cell list heads.
`default_nettype none
module pclb_head_ram #(
  parameter int unsigned DEPTH  = 4096,
  parameter int unsigned ADDR_W = 12,
  parameter int unsigned DATA_W = 13
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: rtl/particle_cell_list_binner_unit.sv
// Top level of the linked cell list binner: config, sequencer and head table.
// A request runs through the one-bit-a-cycle coordinate dividers and a cell index
//   reduction before its response is posted; a first_of_frame request first sweeps
//   the head table while its dividers run.
// Requests: a new one is taken only once the previous response has been posted;
//   a stalled response holds the next request in its write-back step.
// Reset: a sweep writes none into every head entry; no request is taken meanwhile.
`default_nettype none
`include "particle_cell_list_binner_unit_macros.svh"
module particle_cell_list_binner_unit #(
  parameter int unsigned MAX_CELLS = 4096,
  parameter int unsigned MAX_DIM   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  pclb_pkg::req_t                    req_data,
  output logic                              rsp_valid,
  input  logic                              rsp_ready,
  output pclb_pkg::rsp_t                    rsp_data,
  input  logic                              cfg_we,
  input  logic [pclb_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pclb_pkg::CELL_SIZE_W-1:0]  cfg_data
);

  localparam int unsigned QW     = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned SLOT_W = $clog2(MAX_DIM * MAX_DIM);
  localparam int unsigned MSW    = 2;
  localparam int unsigned AW     = $clog2(MAX_CELLS);
  localparam int unsigned PW     = 2 * SLOT_W + 1;
  localparam int unsigned KSH    = SLOT_W + AW;
  // Floor of 2^KSH / MAX_CELLS; the quotient estimate is at most one low.
  localparam longint unsigned RECIP = (64'd1 << KSH) / 64'(MAX_CELLS);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_SLOT  = 7'b0001000,
    S_MOD   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_WRITE = 7'b1000000
  } state_t;

  // Configuration registers.
  logic [pclb_pkg::CELL_SIZE_W-1:0] cell_size;
  logic [pclb_pkg::DIM_REG_W-1:0]   grid_cols;
  logic [pclb_pkg::DIM_REG_W-1:0]   grid_rows;

  // Effective configuration after the zero and range fixes.
  logic [pclb_pkg::CELL_SIZE_W-1:0] cs_eff;
  logic [DIM_W-1:0]                 cols_eff;
  logic [DIM_W-1:0]                 rows_eff;
  logic [QW-1:0]                    hi_col;
  logic [QW-1:0]                    hi_row;

  state_t               state;
  logic                 pend;
  logic [AW-1:0]        clr_addr;
  pclb_pkg::req_t       req_q;
  logic [QW-1:0]        col;
  logic [QW-1:0]        row;
  logic [SLOT_W-1:0]    slot;
  logic [SLOT_W-1:0]    slot_calc;
  logic [AW-1:0]        hrem;
  logic [MSW-1:0]       mstep;
  logic [PW-1:0]        mprod;
  logic [SLOT_W-1:0]    mquo;
  logic [SLOT_W-1:0]    mrem;
  logic [SLOT_W-1:0]    mrem_calc;
  logic [31:0]          mfix;

  logic                 accept;
  logic                 fire;
  logic                 clr_last;

  pclb_pkg::div_stat_t  x_stat;
  pclb_pkg::div_stat_t  y_stat;
  logic [QW-1:0]        qx;
  logic [QW-1:0]        qy;

  logic                        hd_rd_en;
  logic [pclb_pkg::LINK_W-1:0] hd_rd_data;
  logic                        hd_wr_en;
  logic [AW-1:0]               hd_wr_addr;
  logic [pclb_pkg::LINK_W-1:0] hd_wr_data;

  // ---------------------------------------------------------------------------
  // Configuration writes; an index past the register list is dropped.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= pclb_pkg::CELL_SIZE_RST;
      grid_cols <= pclb_pkg::GRID_DIM_RST;
      grid_rows <= pclb_pkg::GRID_DIM_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pclb_pkg::CFG_CELL_SIZE: cell_size <= cfg_data;
        pclb_pkg::CFG_GRID_COLS: grid_cols <= cfg_data[pclb_pkg::DIM_REG_W-1:0];
        pclb_pkg::CFG_GRID_ROWS: grid_rows <= cfg_data[pclb_pkg::DIM_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero cell size acts as the smallest step; grid sizes clamp to 3..MAX_DIM.
  assign cs_eff = (cell_size == '0) ? pclb_pkg::CELL_SIZE_W'(1) : cell_size;

  always_comb begin
    if (grid_cols < pclb_pkg::DIM_REG_W'(3)) begin
      cols_eff = DIM_W'(3);
    end else if (32'(grid_cols) > 32'(MAX_DIM)) begin
      cols_eff = DIM_W'(MAX_DIM);
    end else begin
      cols_eff = DIM_W'(grid_cols);
    end
    if (grid_rows < pclb_pkg::DIM_REG_W'(3)) begin
      rows_eff = DIM_W'(3);
    end else if (32'(grid_rows) > 32'(MAX_DIM)) begin
      rows_eff = DIM_W'(MAX_DIM);
    end else begin
      rows_eff = DIM_W'(grid_rows);
    end
  end

  assign hi_col = QW'(cols_eff - DIM_W'(2));
  assign hi_row = QW'(rows_eff - DIM_W'(2));

  // ---------------------------------------------------------------------------
  // Handshake and sequencer control.
  // ---------------------------------------------------------------------------
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  // Write back and post the response only once the output register is free.
  assign fire      = (state == S_WRITE) && (!rsp_valid || rsp_ready);
  assign clr_last  = (clr_addr == AW'(MAX_CELLS - 1));

  // Both coordinates divide side by side; they start on accept and run
  // during a frame clear sweep as well.
  pclb_coord_div #(
    .QUOT_W (QW)
  ) u_div_x (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .raw     (req_data.pos_x),
    .divisor (cs_eff),
    .hi      (hi_col),
    .stat    (x_stat),
    .q       (qx)
  );

  pclb_coord_div #(
    .QUOT_W (QW)
  ) u_div_y (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .raw     (req_data.pos_y),
    .divisor (cs_eff),
    .hi      (hi_row),
    .stat    (y_stat),
    .q       (qy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      pend      <= 1'b0;
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Post a new response, or drop the one just taken.
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            pend <= 1'b1;
            if (req_data.first_of_frame) begin
              clr_addr <= '0;
              state    <= S_CLEAR;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_CLEAR: begin
          // Sweep the head table; resume the held request afterwards, if any.
          clr_addr <= clr_addr + 1'b1;
          if (clr_last) begin
            state <= pend ? S_DIV : S_IDLE;
          end
        end
        S_DIV: begin
          if (!x_stat.busy && !y_stat.busy) begin
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          state <= S_MOD;
        end
        S_MOD: begin
          if (mstep == '0) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (fire) begin
            pend  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath: cell coordinates, cell index and its reduction into the table.
  // ---------------------------------------------------------------------------
  assign slot_calc = SLOT_W'(col) + SLOT_W'(row) * SLOT_W'(cols_eff);

  // Reduce the cell index modulo the table depth in order: a reciprocal
  // multiply that may come out one low, the remainder it leaves, then
  // one conditional subtract.
  assign mprod     = PW'(slot) * PW'(RECIP);
  assign mrem_calc = slot - SLOT_W'(32'(mquo) * MAX_CELLS);
  assign mfix      = (32'(mrem) >= MAX_CELLS) ? 32'(mrem) - MAX_CELLS : 32'(mrem);

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req_data;
    end
    case (state)
      S_DIV: begin
        col <= qx;
        row <= qy;
      end
      S_SLOT: begin
        slot  <= slot_calc;
        mstep <= MSW'(2);
      end
      S_MOD: begin
        mquo  <= SLOT_W'(mprod >> KSH);
        mrem  <= mrem_calc;
        hrem  <= AW'(mfix);
        mstep <= mstep - 1'b1;
      end
      S_WRITE: begin
        if (fire) begin
          rsp_data.cell_col  <= 6'(col);
          rsp_data.cell_row  <= 6'(row);
          rsp_data.cell_slot <= 12'(slot);
          rsp_data.link_to   <= hd_rd_data;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Head table: read the old head, then push the particle in its place.
  // Read and write never meet in one cycle, so no forwarding is needed.
  // ---------------------------------------------------------------------------
  assign hd_rd_en   = (state == S_READ);
  assign hd_wr_en   = (state == S_CLEAR) || fire;
  assign hd_wr_addr = (state == S_CLEAR) ? clr_addr : hrem;
  assign hd_wr_data = (state == S_CLEAR) ? pclb_pkg::LINK_NONE
                                         : pclb_pkg::LINK_W'(req_q.particle_id);

  pclb_head_ram #(
    .DEPTH  (MAX_CELLS),
    .ADDR_W (AW),
    .DATA_W (pclb_pkg::LINK_W)
  ) u_heads (
    .clk     (clk),
    .rd_en   (hd_rd_en),
    .rd_addr (hrem),
    .rd_data (hd_rd_data),
    .wr_en   (hd_wr_en),
    .wr_addr (hd_wr_addr),
    .wr_data (hd_wr_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `PCLB_ASSERT_NEXT(a_busy_after_req, accept, !req_ready && pend)
  `PCLB_ASSERT_NOW(a_ram_no_overlap, hd_rd_en, !hd_wr_en)
  `PCLB_ASSERT_NEXT(a_fire_posts_rsp, fire, rsp_valid && state == S_IDLE)
  `PCLB_ASSERT_NOW(a_reduced_in_table, state == S_READ, 32'(hrem) < 32'(MAX_CELLS))

endmodule
`default_nettype wire

FILE: tb/sv/particle_cell_list_binner_unit_test.sv
// Self-checking testbench for the linked cell list binner.
`timescale 1ns / 1ps
module particle_cell_list_binner_unit_test;

  // Number of head entries and the run limit in clock cycles.
  localparam int unsigned HEAD_DEPTH = 4096;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // Random requests per configuration phase, and the phase count.
  localparam int unsigned PHASE_ITEMS = 243;
  localparam int unsigned PHASES = 8;
  // Settle time before a register write: the per-request latency plus margin.
  localparam int unsigned SETTLE_CYCLES = 30;
  // Cycles to watch for stray results once everything has arrived.
  localparam int unsigned DRAIN_CYCLES = 40;

  // One directed row: a request, and whether its result is typed in below.
  typedef struct packed {
    logic fixed_rsp;
    pclb_pkg::req_t req;
    pclb_pkg::rsp_t rsp;
  } bin_row_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  pclb_pkg::req_t req_data;
  logic rsp_valid;
  logic rsp_ready;
  pclb_pkg::rsp_t rsp_data;
  logic cfg_we;
  logic [pclb_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pclb_pkg::CELL_SIZE_W-1:0] cfg_data;

  // Mirror of the block's registers and head table.
  logic [pclb_pkg::CELL_SIZE_W-1:0] grid_step;
  logic [pclb_pkg::DIM_REG_W-1:0] grid_cols_reg;
  logic [pclb_pkg::DIM_REG_W-1:0] grid_rows_reg;
  logic [pclb_pkg::LINK_W-1:0] cell_head [HEAD_DEPTH];

  // Results still owed by the block, oldest first.
  pclb_pkg::rsp_t pending_bins [$];
  int unsigned errors;
  int unsigned cycles;
  // Set while neither side idles.
  bit steady;

  // Directed requests at the reset configuration: one cell per unit of position.
  localparam bin_row_t DIRECTED [15] = '{
    // Origin right after reset: clamps to cell (1,1), list empty.
    {1'b1, 1'b0, 12'd0,    24'h000000, 24'h000000, 6'd1,  6'd1,  12'd65,   pclb_pkg::LINK_NONE},
    // Largest positions clamp to the last inner cell.
    {1'b1, 1'b0, 12'd4095, 24'h7FFFFF, 24'h7FFFFF, 6'd62, 6'd62, 12'd4030, pclb_pkg::LINK_NONE},
    // Most negative positions clamp to 1 and chain onto particle 0.
    {1'b1, 1'b0, 12'd1,    24'h800000, 24'h800000, 6'd1,  6'd1,  12'd65,   13'd0},
    // Fraction bits truncate.
    {1'b1, 1'b0, 12'd2048, 24'h005003, 24'h007000, 6'd5,  6'd7,  12'd453,  pclb_pkg::LINK_NONE},
    {1'b1, 1'b0, 12'd1234, 24'h005FFF, 24'h007FFF, 6'd5,  6'd7,  12'd453,  13'd2048},
    // Small negative x clamps to 1.
    {1'b1, 1'b0, 12'd77,   24'hFFFFFF, 24'h00A000, 6'd1,  6'd10, 12'd641,  pclb_pkg::LINK_NONE},
    // New frame: heads cleared before the insert.
    {1'b1, 1'b1, 12'd9,    24'h001000, 24'h001000, 6'd1,  6'd1,  12'd65,   pclb_pkg::LINK_NONE},
    {1'b1, 1'b0, 12'd10,   24'h000FFF, 24'h001FFF, 6'd1,  6'd1,  12'd65,   13'd9},
    // Row 63 clamps to 62; that cell was emptied by the new frame.
    {1'b1, 1'b0, 12'd4095, 24'h03E000, 24'h03F000, 6'd62, 6'd62, 12'd4030, pclb_pkg::LINK_NONE},
    {1'b0, 1'b0, 12'hAAA,  24'h555555, 24'h2AAAAA, 6'd0,  6'd0,  12'd0,    13'd0},
    {1'b0, 1'b0, 12'h555,  24'hAAAAAA, 24'h03F000, 6'd0,  6'd0,  12'd0,    13'd0},
    {1'b1, 1'b0, 12'd3,    24'h03F000, 24'h000000, 6'd62, 6'd1,  12'd126,  pclb_pkg::LINK_NONE},
    // New frame hitting the cell that was just filled.
    {1'b1, 1'b1, 12'd4095, 24'h7FFFFF, 24'h000000, 6'd62, 6'd1,  12'd126,  pclb_pkg::LINK_NONE},
    {1'b1, 1'b0, 12'd5,    24'h010000, 24'h020000, 6'd16, 6'd32, 12'd2064, pclb_pkg::LINK_NONE},
    {1'b1, 1'b0, 12'd6,    24'h010000, 24'h020000, 6'd16, 6'd32, 12'd2064, 13'd5}
  };

  // Fixed settings of the first phases; the rest are drawn at random.
  localparam logic [pclb_pkg::CELL_SIZE_W-1:0] PHASE_STEP [6] =
    '{23'd3072, 23'd0, 23'h7FFFFF, 23'd1, 23'd16384, 23'd2048};
  localparam logic [pclb_pkg::DIM_REG_W-1:0] PHASE_COLS [6] =
    '{7'd20, 7'd0, 7'd127, 7'd3, 7'd64, 7'd2};
  localparam logic [pclb_pkg::DIM_REG_W-1:0] PHASE_ROWS [6] =
    '{7'd45, 7'd1, 7'd127, 7'd64, 7'd3, 7'd65};

  particle_cell_list_binner_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run; a hung handshake ends here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Grid dimension as the block uses it: below 3 acts as 3, above 64 as 64.
  function automatic int unsigned clamp_dim(logic [pclb_pkg::DIM_REG_W-1:0] d);
    if (d < 3) return 3;
    if (d > 64) return 64;
    return d;
  endfunction

  // Truncated quotient of one coordinate, clamped to the inner cells.
  function automatic logic [5:0] cell_coord(logic [pclb_pkg::POS_W-1:0] pos,
                                            int unsigned step, int unsigned dim);
    int unsigned q;
    if (pos[pclb_pkg::POS_W-1]) return 6'd1;
    q = pos / step;
    if (q < 1) q = 1;
    else if (q > dim - 2) q = dim - 2;
    return q[5:0];
  endfunction

  // Bin one particle: work out its cell, read the old head, push the particle.
  function automatic pclb_pkg::rsp_t bin_particle(pclb_pkg::req_t r);
    int unsigned step;
    int unsigned cols;
    int unsigned rows;
    int unsigned slot;
    pclb_pkg::rsp_t res;
    step = (grid_step == 0) ? 1 : grid_step;
    cols = clamp_dim(grid_cols_reg);
    rows = clamp_dim(grid_rows_reg);
    if (r.first_of_frame) begin
      foreach (cell_head[i]) cell_head[i] = pclb_pkg::LINK_NONE;
    end
    res.cell_col = cell_coord(r.pos_x, step, cols);
    res.cell_row = cell_coord(r.pos_y, step, rows);
    slot = res.cell_col + res.cell_row * cols;
    res.cell_slot = slot[11:0];
    res.link_to = cell_head[slot[11:0]];
    cell_head[slot[11:0]] = {1'b0, r.particle_id};
    return res;
  endfunction

  // Draw a coordinate: mostly inside the grid, so lists grow, else anywhere.
  function automatic logic [pclb_pkg::POS_W-1:0] pick_pos(int unsigned dim);
    int unsigned pick;
    int unsigned step;
    longint unsigned v;
    pick = $urandom_range(0, 99);
    step = (grid_step == 0) ? 1 : grid_step;
    if (pick < 60) begin
      v = longint'($urandom_range(0, dim)) * step + ($urandom % step);
      if (v <= 64'h7FFFFF) return v[pclb_pkg::POS_W-1:0];
      return pclb_pkg::POS_W'($urandom);
    end
    if (pick < 75) return {1'b1, 23'($urandom)};
    return pclb_pkg::POS_W'($urandom);
  endfunction

  function automatic pclb_pkg::req_t random_bin();
    pclb_pkg::req_t r;
    r.first_of_frame = ($urandom_range(0, 63) == 0);
    r.particle_id = pclb_pkg::PID_W'($urandom);
    r.pos_x = pick_pos(clamp_dim(grid_cols_reg));
    r.pos_y = pick_pos(clamp_dim(grid_rows_reg));
    return r;
  endfunction

  // Offer one request; record its expected result once it is accepted.
  task automatic send_bin(pclb_pkg::req_t r, logic fixed_rsp, pclb_pkg::rsp_t want);
    pclb_pkg::rsp_t got_pred;
    @(negedge clk);
    // Idle the request side now and then.
    while (!steady && $urandom_range(0, 99) < 19) begin
      req_valid = 1'b0;
      @(negedge clk);
    end
    req_valid = 1'b1;
    req_data = r;
    do @(posedge clk); while (!req_ready);
    // Advance the model even when the result is typed in.
    got_pred = bin_particle(r);
    pending_bins = {pending_bins, (fixed_rsp ? want : got_pred)};
  endtask

  // Write all three registers once the block has gone quiet.
  task automatic set_grid(logic [pclb_pkg::CELL_SIZE_W-1:0] step,
                          logic [pclb_pkg::DIM_REG_W-1:0] cols,
                          logic [pclb_pkg::DIM_REG_W-1:0] rows);
    @(negedge clk);
    req_valid = 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = pclb_pkg::CFG_CELL_SIZE;
    cfg_data = step;
    @(negedge clk);
    cfg_index = pclb_pkg::CFG_GRID_COLS;
    cfg_data = {16'd0, cols};
    @(negedge clk);
    cfg_index = pclb_pkg::CFG_GRID_ROWS;
    cfg_data = {16'd0, rows};
    @(negedge clk);
    cfg_we = 1'b0;
    grid_step = step;
    grid_cols_reg = cols;
    grid_rows_reg = rows;
  endtask

  // Result side: stall at random, check each accepted result against the oldest owed.
  initial begin
    pclb_pkg::rsp_t want;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) begin
        if (pending_bins.size() == 0) begin
          $display("%0t unexpected bin result: col %0d row %0d slot %0d link %0d", $time,
                   rsp_data.cell_col, rsp_data.cell_row, rsp_data.cell_slot, rsp_data.link_to);
          errors++;
        end else begin
          want = pending_bins.pop_front();
          if (rsp_data.cell_col !== want.cell_col) begin
            $display("%0t bin mismatch cell_col: expected %0d, got %0d", $time,
                     want.cell_col, rsp_data.cell_col);
            errors++;
          end
          if (rsp_data.cell_row !== want.cell_row) begin
            $display("%0t bin mismatch cell_row: expected %0d, got %0d", $time,
                     want.cell_row, rsp_data.cell_row);
            errors++;
          end
          if (rsp_data.cell_slot !== want.cell_slot) begin
            $display("%0t bin mismatch cell_slot: expected %0d, got %0d", $time,
                     want.cell_slot, rsp_data.cell_slot);
            errors++;
          end
          if (rsp_data.link_to !== want.link_to) begin
            $display("%0t bin mismatch link_to: expected %0d, got %0d", $time,
                     want.link_to, rsp_data.link_to);
            errors++;
          end
        end
      end
      @(negedge clk);
      rsp_ready = steady || ($urandom_range(0, 99) >= 19);
    end
  end

  // Stimulus: reset, directed table, then random phases under changing settings.
  initial begin
    int unsigned ph;
    logic [pclb_pkg::CELL_SIZE_W-1:0] step;
    logic [pclb_pkg::DIM_REG_W-1:0] cols;
    logic [pclb_pkg::DIM_REG_W-1:0] rows;
    rst = 1'b1;
    req_valid = 1'b0;
    req_data = '0;
    rsp_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = pclb_pkg::CFG_CELL_SIZE;
    cfg_data = '0;
    errors = 0;
    steady = 1'b0;
    grid_step = pclb_pkg::CELL_SIZE_RST;
    grid_cols_reg = pclb_pkg::GRID_DIM_RST;
    grid_rows_reg = pclb_pkg::GRID_DIM_RST;
    foreach (cell_head[i]) cell_head[i] = pclb_pkg::LINK_NONE;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    // The block sweeps its head table after reset; the first request just waits.
    foreach (DIRECTED[i]) send_bin(DIRECTED[i].req, DIRECTED[i].fixed_rsp, DIRECTED[i].rsp);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph < 6) begin
        step = PHASE_STEP[ph];
        cols = PHASE_COLS[ph];
        rows = PHASE_ROWS[ph];
      end else begin
        step = pclb_pkg::CELL_SIZE_W'($urandom);
        cols = pclb_pkg::DIM_REG_W'($urandom_range(0, 127));
        rows = pclb_pkg::DIM_REG_W'($urandom_range(0, 127));
      end
      set_grid(step, cols, rows);
      // Hold both sides busy for one whole phase.
      steady = (ph == 3);
      repeat (PHASE_ITEMS) send_bin(random_bin(), 1'b0, '0);
    end

    // Drop the request, drain what is owed, then watch for strays.
    @(negedge clk);
    req_valid = 1'b0;
    steady = 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
